// File: rtl/rapt_pkg.sv
// rapt_pkg: shared item types, codes and fixed point helpers for the active pair transform
package rapt_pkg;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_FACTOR = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_FACTOR = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    localparam logic [1:0] CFG_BASIS  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE = 2'd1;
    localparam logic [1:0] CFG_GRAM   = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] value;
        logic               row_last;
        logic [9:0]         read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         pair_index;
        logic signed [63:0] result_value;
        logic               status;
        logic               last;
    } t_out_item;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    // floor of a signed magnitude product over 2^32, saturated
    function automatic logic signed [63:0] q32_floor(input logic [127:0] prod,
                                                     input logic neg);
        logic [63:0] q;
        logic [64:0] qq;
        q  = prod[95:32];
        qq = {1'b0, q} + {64'd0, |prod[31:0]};
        if (|prod[127:96]) return neg ? S64_MIN : S64_MAX;
        if (!neg) return q[63] ? S64_MAX : signed'(q);
        if (qq > {2'b01, 63'd0}) return S64_MIN;
        return signed'(64'(65'd0 - qq));
    endfunction

endpackage

// File: rtl/rapt_mul.sv
// rapt_mul: shared signed multiplier with registered product
module rapt_mul (
    input  logic                                  i_clk,
    input  logic signed [rapt_pkg::MUL_W-1:0]     i_a,
    input  logic signed [rapt_pkg::MUL_W-1:0]     i_b,
    output logic signed [rapt_pkg::PROD_W-1:0]    o_p
);
    import rapt_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: rtl/ri_active_pair_transform.sv
// ri_active_pair_transform: sequencer, stores and datapath of the active pair transform
//
// channel   direction  handshake                   payload
// item      in         i_start, o_busy             i_item (t_in_item)
// result    out        o_strobe, one cycle         o_result (t_out_item)
// config    in         i_cfg_valid, o_cfg_ready    i_cfg_index, i_cfg_data
//
// load is acknowledged from idle; read passes through S_RD; clear zeroes all GD gram entries (GD = 666 by default)
// factor element: states S_E0 to S_E7 per active pair through the one shared multiplier
// row end: each gram term runs S_G0 to S_G2, S_GM/S_GA, S_GF and S_GW when enabled, then each result S_O0 and S_O1
// after reset a gram clearing pass over all GD entries holds o_busy high
// results cannot be stalled; o_strobe marks each one for a single cycle
module ri_active_pair_transform #(
    parameter int MAX_BASIS  = 16,
    parameter int MAX_ACTIVE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  rapt_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output rapt_pkg::t_out_item  o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data
);
    import rapt_pkg::*;

    localparam int CD  = MAX_BASIS * MAX_ACTIVE;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
    localparam int NP  = MAX_ACTIVE * (MAX_ACTIVE + 1) / 2;
    localparam int PAW = (NP > 1) ? $clog2(NP) : 1;
    localparam int PCW = PAW + 1;
    localparam int GD  = NP * (NP + 1) / 2;
    localparam int GAW = (GD > 1) ? $clog2(GD) : 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_E0   = 5'd3;
    localparam logic [4:0] S_E1   = 5'd4;
    localparam logic [4:0] S_E2   = 5'd5;
    localparam logic [4:0] S_E3   = 5'd6;
    localparam logic [4:0] S_E4   = 5'd7;
    localparam logic [4:0] S_E5   = 5'd8;
    localparam logic [4:0] S_E6   = 5'd9;
    localparam logic [4:0] S_E7   = 5'd10;
    localparam logic [4:0] S_END  = 5'd11;
    localparam logic [4:0] S_G0   = 5'd12;
    localparam logic [4:0] S_G1   = 5'd13;
    localparam logic [4:0] S_G2   = 5'd14;
    localparam logic [4:0] S_GM   = 5'd15;
    localparam logic [4:0] S_GA   = 5'd16;
    localparam logic [4:0] S_GF   = 5'd17;
    localparam logic [4:0] S_GW   = 5'd18;
    localparam logic [4:0] S_O0   = 5'd19;
    localparam logic [4:0] S_O1   = 5'd20;

    function automatic logic [CAW-1:0] caddr(input logic [3:0] row, input logic [3:0] col);
        return CAW'(32'(row) * MAX_ACTIVE + 32'(col));
    endfunction

    // configuration
    logic [4:0] r_basis;
    logic [3:0] r_active;
    logic       r_gram_en;

    // sequencer
    logic [4:0]         r_state;
    logic [3:0]         r_mu, r_nu, r_p, r_q;
    logic signed [31:0] r_val;
    logic               r_last;
    logic               r_ack_clr;
    logic [9:0]         r_ridx;
    logic [PCW-1:0]     r_k, r_i, r_j;
    logic [GAW-1:0]     r_g;
    logic signed [31:0] r_a;
    logic signed [33:0] r_s;
    logic               r_sa, r_neg;
    logic [63:0]        r_ua, r_ub;
    logic [127:0]       r_prod;
    logic [1:0]         r_pp;
    logic signed [63:0] r_t;
    logic               r_strobe;
    t_out_item          r_out;

    // stores
    logic signed [31:0] r_cmem [CD];
    logic [CD-1:0]      r_cvalid;
    logic signed [31:0] r_crd;
    logic               r_crv;
    logic signed [63:0] r_amem [NP];
    logic [NP-1:0]      r_avalid;
    logic signed [63:0] r_ard;
    logic               r_arv;
    logic signed [63:0] r_gmem [GD];
    logic signed [63:0] r_grd;

    logic [4:0]          eff_nb;
    logic [3:0]          eff_na;
    logic [PCW-1:0]      np;
    logic                accept;
    logic                load_bad, load_ok;
    logic signed [31:0]  coef_q;
    logic signed [63:0]  acc_q;
    logic [CAW-1:0]      coef_raddr;
    logic                acc_re, acc_we;
    logic [PAW-1:0]      acc_raddr;
    logic signed [63:0]  acc_sum;
    logic                gram_re, gram_we;
    logic [GAW-1:0]      gram_raddr;
    logic signed [63:0]  gram_wd;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] mul_sh31, mul_sh20;
    logic [6:0]          pp_shift;

    assign eff_nb = (32'(r_basis) > MAX_BASIS) ? 5'(MAX_BASIS) : r_basis;
    assign eff_na = (32'(r_active) > MAX_ACTIVE) ? 4'(MAX_ACTIVE) : r_active;
    assign np     = PCW'((32'(eff_na) * (32'(eff_na) + 32'd1)) >> 1);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;
    assign accept      = i_start && !o_busy;

    assign load_bad = (i_item.col_index >= eff_na);
    assign load_ok  = !load_bad && ({1'b0, i_item.row_index} < eff_nb);

    assign coef_q = r_crv ? r_crd : 32'sd0;
    assign acc_q  = r_arv ? r_ard : 64'sd0;

    assign mul_sh31 = mul_p >>> 31;
    assign mul_sh20 = mul_p >>> 20;
    assign acc_sum  = sat_add64(acc_q, 64'(mul_sh20));
    assign pp_shift = {r_pp[1] && r_pp[0], r_pp[1] ^ r_pp[0], 5'd0};

    rapt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // store ports and shared unit operands
    always_comb begin
        coef_raddr = caddr(r_mu, r_p);
        acc_re     = 1'b0;
        acc_raddr  = PAW'(r_k);
        acc_we     = 1'b0;
        gram_re    = 1'b0;
        gram_raddr = GAW'(32'(i_item.read_index));
        gram_we    = 1'b0;
        gram_wd    = 64'sd0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            S_IDLE: begin
                gram_re = accept && (i_item.mode == MODE_READ);
            end
            S_CLR: begin
                gram_we = 1'b1;
            end
            S_E0: begin
                acc_re = 1'b1;
            end
            S_E1: begin
                coef_raddr = caddr(r_nu, r_q);
            end
            S_E2: begin
                coef_raddr = caddr(r_nu, r_p);
                mul_a      = MUL_W'(r_a);
                mul_b      = MUL_W'(coef_q);
            end
            S_E3: begin
                coef_raddr = caddr(r_mu, r_q);
            end
            S_E4: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(coef_q);
            end
            S_E6: begin
                mul_a = r_s;
                mul_b = MUL_W'(r_val);
            end
            S_E7: begin
                acc_we = 1'b1;
            end
            S_G0: begin
                acc_re    = 1'b1;
                acc_raddr = PAW'(r_i);
            end
            S_G1: begin
                acc_re    = 1'b1;
                acc_raddr = PAW'(r_j);
            end
            S_G2: begin
                gram_re    = 1'b1;
                gram_raddr = r_g;
            end
            S_GM: begin
                mul_a = {2'b00, r_pp[1] ? r_ua[63:32] : r_ua[31:0]};
                mul_b = {2'b00, r_pp[0] ? r_ub[63:32] : r_ub[31:0]};
            end
            S_GW: begin
                gram_we = 1'b1;
                gram_wd = sat_add64(r_grd, r_t);
            end
            S_O0: begin
                acc_re    = 1'b1;
                acc_raddr = PAW'(r_i);
            end
            default: begin
            end
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.mode == MODE_LOAD) && load_ok) begin
            r_cmem[caddr(i_item.row_index, i_item.col_index)] <= i_item.value;
        end
        r_crd <= r_cmem[coef_raddr];
        r_crv <= r_cvalid[coef_raddr];
        if (acc_we) begin
            r_amem[PAW'(r_k)] <= acc_sum;
        end
        if (acc_re) begin
            r_ard <= r_amem[acc_raddr];
            r_arv <= r_avalid[acc_raddr];
        end
        if (gram_we) begin
            r_gmem[r_g] <= gram_wd;
        end
        if (gram_re) begin
            r_grd <= r_gmem[gram_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis   <= 5'd16;
            r_active  <= 4'd8;
            r_gram_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASIS:  r_basis   <= i_cfg_data;
                CFG_ACTIVE: r_active  <= i_cfg_data[3:0];
                CFG_GRAM:   r_gram_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_g       <= '0;
            r_ack_clr <= 1'b0;
            r_strobe  <= 1'b0;
            r_cvalid  <= '0;
            r_avalid  <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (acc_we) begin
                r_avalid[PAW'(r_k)] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_item.mode)
                            MODE_LOAD: begin
                                if (load_ok) begin
                                    r_cvalid[caddr(i_item.row_index, i_item.col_index)] <= 1'b1;
                                end
                                r_strobe <= 1'b1;
                                r_out    <= '{KIND_ACK, 10'd0, 64'sd0, load_bad, 1'b1};
                            end
                            MODE_READ: begin
                                r_ridx  <= i_item.read_index;
                                r_state <= S_RD;
                            end
                            MODE_CLEAR: begin
                                r_cvalid  <= '0;
                                r_avalid  <= '0;
                                r_g       <= '0;
                                r_ack_clr <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: begin
                                if (i_item.col_index > i_item.row_index) begin
                                    r_mu <= i_item.col_index;
                                    r_nu <= i_item.row_index;
                                end else begin
                                    r_mu <= i_item.row_index;
                                    r_nu <= i_item.col_index;
                                end
                                r_val  <= i_item.value;
                                r_last <= i_item.row_last;
                                r_p    <= 4'd0;
                                r_q    <= 4'd0;
                                r_k    <= '0;
                                if (({1'b0, i_item.row_index} < eff_nb)
                                        && ({1'b0, i_item.col_index} < eff_nb)
                                        && (eff_na != 4'd0)) begin
                                    r_state <= S_E0;
                                end else begin
                                    r_state <= S_END;
                                end
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_g == GAW'(GD - 1)) begin
                        if (r_ack_clr) begin
                            r_strobe <= 1'b1;
                            r_out    <= '{KIND_ACK, 10'd0, 64'sd0, 1'b0, 1'b1};
                        end
                        r_ack_clr <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_g <= r_g + 1'b1;
                    end
                end
                S_RD: begin
                    r_strobe <= 1'b1;
                    r_out    <= '{KIND_READ, r_ridx,
                                  (32'(r_ridx) < GD) ? r_grd : 64'sd0, 1'b0, 1'b1};
                    r_state  <= S_IDLE;
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_a     <= coef_q;
                    r_state <= S_E2;
                end
                S_E2: r_state <= S_E3;
                S_E3: begin
                    r_s     <= 34'(mul_sh31);
                    r_a     <= coef_q;
                    r_state <= S_E4;
                end
                S_E4: r_state <= S_E5;
                S_E5: begin
                    if (r_mu != r_nu) begin
                        r_s <= r_s + 34'(mul_sh31);
                    end
                    r_state <= S_E6;
                end
                S_E6: r_state <= S_E7;
                S_E7: begin
                    r_k <= r_k + 1'b1;
                    if (r_q == r_p) begin
                        if (r_p == eff_na - 4'd1) begin
                            r_state <= S_END;
                        end else begin
                            r_p     <= r_p + 4'd1;
                            r_q     <= 4'd0;
                            r_state <= S_E0;
                        end
                    end else begin
                        r_q     <= r_q + 4'd1;
                        r_state <= S_E0;
                    end
                end
                S_END: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_g <= '0;
                    priority if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_gram_en && (np != '0)) begin
                        r_state <= S_G0;
                    end else begin
                        r_state <= S_O0;
                    end
                end
                S_G0: r_state <= S_G1;
                S_G1: begin
                    r_sa    <= acc_q[63];
                    r_ua    <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_neg   <= r_sa ^ acc_q[63];
                    r_ub    <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
                    r_prod  <= '0;
                    r_pp    <= 2'd0;
                    r_state <= S_GM;
                end
                S_GM: r_state <= S_GA;
                S_GA: begin
                    r_prod <= r_prod + ({64'd0, mul_p[63:0]} << pp_shift);
                    if (r_pp == 2'd3) begin
                        r_state <= S_GF;
                    end else begin
                        r_pp    <= r_pp + 2'd1;
                        r_state <= S_GM;
                    end
                end
                S_GF: begin
                    r_t     <= q32_floor(r_prod, r_neg);
                    r_state <= S_GW;
                end
                S_GW: begin
                    r_g     <= r_g + 1'b1;
                    r_state <= S_G0;
                    if (r_j == r_i) begin
                        if (r_i == np - 1'b1) begin
                            r_i     <= '0;
                            r_state <= S_O0;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= '0;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_O0: begin
                    if (np == '0) begin
                        r_strobe <= 1'b1;
                        r_out    <= '{KIND_ACK, 10'd0, 64'sd0, 1'b0, 1'b1};
                        r_avalid <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_O1;
                    end
                end
                S_O1: begin
                    r_strobe <= 1'b1;
                    r_out    <= '{KIND_FACTOR, 10'(r_i), acc_q, 1'b0, (r_i == np - 1'b1)};
                    if (r_i == np - 1'b1) begin
                        r_avalid <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_O0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
